### hdl/rgbpm_pkg.sv
// Shared types and constants for the RGBA premultiply pixel packer.
package rgbpm_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 2;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB8   = 2'd1,
    FMT_RGBA8  = 2'd2,
    FMT_RAW    = 2'd3
  } fmt_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SWAP   = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RGB565 = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_RGB8   = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_RGBA8  = 3'd4;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              end_of_image;
  } pix_t;

  typedef struct packed {
    fmt_t fmt;
    logic swap;
  } cfg_t;

endpackage

### hdl/rgbpm_pack.sv
// Combinational premultiply and byte packing for one pixel.
module rgbpm_pack (
  input  rgbpm_pkg::pix_t                   pix,
  input  rgbpm_pkg::cfg_t                   cfg,
  output logic [rgbpm_pkg::WORD_W-1:0]      packed_bytes,
  output logic [rgbpm_pkg::COUNT_W-1:0]     byte_count
);
  import rgbpm_pkg::*;

  // floor(c*a/255) for products up to 255*255: (p + (p >> 8) + 1) >> 8
  // The sum peaks at 65280, so it stays within 16 bits.
  function automatic logic [CHAN_W-1:0] premul(input logic [CHAN_W-1:0] c,
                                               input logic [CHAN_W-1:0] a);
    logic [2*CHAN_W-1:0] prod;
    logic [2*CHAN_W-1:0] sum;
    prod = {{CHAN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, a};
    sum  = prod + {{CHAN_W{1'b0}}, prod[2*CHAN_W-1:CHAN_W]} + (2*CHAN_W)'(1);
    return sum[2*CHAN_W-1:CHAN_W];
  endfunction

  logic [CHAN_W-1:0] pr, pg, pb;

  assign pr = premul(pix.red,   pix.alpha);
  assign pg = premul(pix.green, pix.alpha);
  assign pb = premul(pix.blue,  pix.alpha);

  always_comb begin
    unique case (cfg.fmt)
      FMT_RGB565: begin
        if (cfg.swap) begin
          packed_bytes = {16'd0, pb[7:3], pg[7:2], pr[7:3]};
        end else begin
          packed_bytes = {16'd0, pr[7:3], pg[7:2], pb[7:3]};
        end
        byte_count = COUNT_RGB565;
      end
      FMT_RGB8: begin
        if (cfg.swap) begin
          packed_bytes = {8'd0, pr, pg, pb};
        end else begin
          packed_bytes = {8'd0, pb, pg, pr};
        end
        byte_count = COUNT_RGB8;
      end
      FMT_RGBA8: begin
        if (cfg.swap) begin
          packed_bytes = {pix.red, pix.green, pix.blue, pix.alpha};
        end else begin
          packed_bytes = {pix.alpha, pix.blue, pix.green, pix.red};
        end
        byte_count = COUNT_RGBA8;
      end
      FMT_RAW: begin
        // unused code: plain RGBA bytes, swap ignored
        packed_bytes = {pix.alpha, pix.blue, pix.green, pix.red};
        byte_count   = COUNT_RGBA8;
      end
      default: begin
        packed_bytes = {pix.alpha, pix.blue, pix.green, pix.red};
        byte_count   = COUNT_RGBA8;
      end
    endcase
  end

endmodule

### hdl/rgba_premultiply_pixel_packer_core.sv
// Top level of the RGBA premultiply pixel packer.
// Converts one RGBA8 pixel per transfer into RGB565, RGB8 or RGBA8 bytes,
// little-endian in out_packed_bytes with out_byte_count valid bytes. Colour
// channels are premultiplied by alpha as floor(c*a/255) for RGB565 and RGB8.
// Takes one pixel per clock while the output is not stalled. A pixel is
// captured in the input register and then moves on to the result register,
// with the 8x8 multipliers and the divide-by-255 correction between them.
// The result register stalls independently: the input register can still
// take one pixel while a result waits, and ready falls only when both are
// full.
// Configuration (cfg_index 0 = output_format, 1 = swap_order) is always
// accepted; write it only while no pixel is in flight. Other indexes are
// ignored.
module rgba_premultiply_pixel_packer_core (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbpm_pkg::CFG_DAT_W-1:0]   cfg_data,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbpm_pkg::CHAN_W-1:0]      in_red,
  input  logic [rgbpm_pkg::CHAN_W-1:0]      in_green,
  input  logic [rgbpm_pkg::CHAN_W-1:0]      in_blue,
  input  logic [rgbpm_pkg::CHAN_W-1:0]      in_alpha,
  input  logic                              in_end_of_image,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rgbpm_pkg::WORD_W-1:0]      out_packed_bytes,
  output logic [rgbpm_pkg::COUNT_W-1:0]     out_byte_count,
  output logic                              out_last_pixel_out
);
  import rgbpm_pkg::*;

  cfg_t cfg_r;

  pix_t pix_r;
  logic pix_valid_r;

  logic [WORD_W-1:0]  packed_nxt;
  logic [COUNT_W-1:0] count_nxt;

  logic [WORD_W-1:0]  out_packed_bytes_r;
  logic [COUNT_W-1:0] out_byte_count_r;
  logic               out_last_r;
  logic               out_valid_r;

  logic out_load;
  logic pix_load;

  // Configuration registers: always ready, masked to field width.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt  <= FMT_RGB565;
      cfg_r.swap <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_FORMAT) begin
        cfg_r.fmt <= fmt_t'(cfg_data);
      end else if (cfg_index == CFG_IDX_SWAP) begin
        cfg_r.swap <= cfg_data[0];
      end
    end
  end

  // Result register takes a new value when empty or being drained.
  assign out_load = !out_valid_r || out_ready;
  // Input register advances whenever its content moves on or it is empty.
  assign in_ready = !pix_valid_r || out_load;
  assign pix_load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_ready) begin
      pix_valid_r <= in_valid;
    end
  end

  // Hold the pixel payload; no reset needed.
  always_ff @(posedge clk) begin
    if (pix_load) begin
      pix_r.red          <= in_red;
      pix_r.green        <= in_green;
      pix_r.blue         <= in_blue;
      pix_r.alpha        <= in_alpha;
      pix_r.end_of_image <= in_end_of_image;
    end
  end

  rgbpm_pack u_pack (
    .pix          (pix_r),
    .cfg          (cfg_r),
    .packed_bytes (packed_nxt),
    .byte_count   (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= pix_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && pix_valid_r) begin
      out_packed_bytes_r <= packed_nxt;
      out_byte_count_r   <= count_nxt;
      out_last_r         <= pix_r.end_of_image;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_packed_bytes   = out_packed_bytes_r;
  assign out_byte_count     = out_byte_count_r;
  assign out_last_pixel_out = out_last_r;

endmodule

### hdl/rgbpm_checker.sv
// Port-level checks for the pixel packer, bound to the top level.
module rgbpm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rgbpm_pkg::WORD_W-1:0]      out_packed_bytes,
  input logic [rgbpm_pkg::COUNT_W-1:0]     out_byte_count
);
  import rgbpm_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packed_bytes)
                                && $stable(out_byte_count))
    else $error("stalled result changed");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == COUNT_RGB565 || out_byte_count == COUNT_RGB8
                   || out_byte_count == COUNT_RGBA8))
    else $error("illegal byte count");

  a_rgb565_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == COUNT_RGB565 |-> out_packed_bytes[31:16] == 16'd0)
    else $error("RGB565 word has upper bytes set");

  a_rgb8_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == COUNT_RGB8 |-> out_packed_bytes[31:24] == 8'd0)
    else $error("RGB8 word has top byte set");

endmodule

bind rgba_premultiply_pixel_packer_core rgbpm_checker u_rgbpm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_packed_bytes (out_packed_bytes),
  .out_byte_count   (out_byte_count)
);

### sim/tb_rgba_premultiply_pixel_packer_core.sv
// Self-checking testbench for the RGBA premultiply pixel packer core.
`timescale 1ns / 1ps

module tb_rgba_premultiply_pixel_packer_core;
  import rgbpm_pkg::*;

  // Expected result of one pixel, one field per output port.
  typedef struct packed {
    logic [WORD_W-1:0]  packed_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               last_pixel_out;
  } pack_result_t;

  // The block ignores these register indexes; write them now and then anyway.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam int unsigned RANDOM_PIXELS = 1150;
  localparam int unsigned HOLD_CYCLES   = 200;
  // Extra settle time after the last packed word has come back.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TIMEOUT_NS    = 3_000_000;
  localparam int unsigned MAX_PRINTS    = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  logic              in_valid        = 1'b0;
  logic              in_ready;
  logic [CHAN_W-1:0] in_red          = '0;
  logic [CHAN_W-1:0] in_green        = '0;
  logic [CHAN_W-1:0] in_blue         = '0;
  logic [CHAN_W-1:0] in_alpha        = '0;
  logic              in_end_of_image = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WORD_W-1:0]  out_packed_bytes;
  logic [COUNT_W-1:0] out_byte_count;
  logic               out_last_pixel_out;

  rgba_premultiply_pixel_packer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_alpha           (in_alpha),
    .in_end_of_image    (in_end_of_image),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_packed_bytes   (out_packed_bytes),
    .out_byte_count     (out_byte_count),
    .out_last_pixel_out (out_last_pixel_out)
  );

  // Pixels waiting to be driven, and packed words waiting to come out.
  pix_t         pixel_q[$];
  pack_result_t awaited_q[$];

  // Shadow copy of the two registers, updated on each config transfer to their indexes.
  fmt_t shadow_fmt  = FMT_RGB565;
  logic shadow_swap = 1'b0;

  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned cfg_count      = 0;
  int unsigned err_count      = 0;

  // Handshake seen at the last rising edge, read by the driver at the falling edge.
  logic in_fire = 1'b0;

  // Idle controls set per phase by the stimulus block.
  logic        send_gaps_on = 1'b1;
  logic        recv_gaps_on = 1'b1;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  pix_t         drv_pix;
  pack_result_t got_word;
  pack_result_t want_word;

  initial begin
    forever #2 clk = ~clk;
  end

  // Premultiply (RGB565 and RGB8 only) and pack one pixel for the given register settings.
  function automatic pack_result_t pack_pixel(pix_t p, fmt_t f, logic sw);
    logic [15:0]  pm_r;
    logic [15:0]  pm_g;
    logic [15:0]  pm_b;
    pack_result_t r;
    pm_r = ({8'd0, p.red}   * {8'd0, p.alpha}) / 16'd255;
    pm_g = ({8'd0, p.green} * {8'd0, p.alpha}) / 16'd255;
    pm_b = ({8'd0, p.blue}  * {8'd0, p.alpha}) / 16'd255;
    r.last_pixel_out = p.end_of_image;
    case (f)
      FMT_RGB565: begin
        if (sw) r.packed_bytes = {16'd0, pm_b[7:3], pm_g[7:2], pm_r[7:3]};
        else    r.packed_bytes = {16'd0, pm_r[7:3], pm_g[7:2], pm_b[7:3]};
        r.byte_count = COUNT_RGB565;
      end
      FMT_RGB8: begin
        // First byte lands in bits 7:0, so red sits lowest without swap.
        if (sw) r.packed_bytes = {8'd0, pm_r[7:0], pm_g[7:0], pm_b[7:0]};
        else    r.packed_bytes = {8'd0, pm_b[7:0], pm_g[7:0], pm_r[7:0]};
        r.byte_count = COUNT_RGB8;
      end
      FMT_RGBA8: begin
        if (sw) r.packed_bytes = {p.red, p.green, p.blue, p.alpha};
        else    r.packed_bytes = {p.alpha, p.blue, p.green, p.red};
        r.byte_count = COUNT_RGBA8;
      end
      default: begin
        // Unused format code: plain RGBA bytes, swap has no effect.
        r.packed_bytes = {p.alpha, p.blue, p.green, p.red};
        r.byte_count   = COUNT_RGBA8;
      end
    endcase
    return r;
  endfunction

  // Most gaps are zero or short, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Lean on the extremes, where rounding and truncation bite.
  function automatic logic [CHAN_W-1:0] pick_chan(int unsigned edge_pct);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < edge_pct)     return 8'h00;
    if (k < 2 * edge_pct) return 8'hFF;
    return CHAN_W'($urandom);
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                           logic eoi);
    pix_t p;
    p.red          = r;
    p.green        = g;
    p.blue         = b;
    p.alpha        = a;
    p.end_of_image = eoi;
    pixel_q.push_back(p);
    pushed_count++;
  endtask

  // Call at a falling edge; returns at the falling edge after the transfer,
  // with cfg_valid still high so writes can go back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    int unsigned c0;
    c0 = cfg_count;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (cfg_count == c0);
  endtask

  // Write both registers, sometimes with a stray write to a spare index.
  task automatic apply_config(logic [CFG_DAT_W-1:0] fmt_data,
                              logic [CFG_DAT_W-1:0] swap_data);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_SPARE_LO, CFG_DAT_W'($urandom));
    write_reg(CFG_IDX_FORMAT, fmt_data);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_SPARE_HI, CFG_DAT_W'($urandom));
    write_reg(CFG_IDX_SWAP, swap_data);
    cfg_valid <= 1'b0;
  endtask

  // Block until every pushed pixel is taken and every packed word has come back.
  task automatic wait_drained();
    while (accepted_count != pushed_count || awaited_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: hold the payload until the transfer, then idle or present the next pixel.
  always @(negedge clk) begin
    if (in_valid && !in_fire) begin
      // hold until accepted
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (rst_n && pixel_q.size() != 0) begin
      drv_pix = pixel_q.pop_front();
      in_red          <= drv_pix.red;
      in_green        <= drv_pix.green;
      in_blue         <= drv_pix.blue;
      in_alpha        <= drv_pix.alpha;
      in_end_of_image <= drv_pix.end_of_image;
      in_valid        <= 1'b1;
      send_gap = send_gaps_on ? pick_gap() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a requested long hold-off wins over the random stalls.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_stall = recv_gaps_on ? pick_gap() : 0;
    end
  end

  // Monitor: track config, predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_count++;
        case (cfg_index)
          CFG_IDX_FORMAT: shadow_fmt  = fmt_t'(cfg_data);
          CFG_IDX_SWAP:   shadow_swap = cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        drv_pix.red          = in_red;
        drv_pix.green        = in_green;
        drv_pix.blue         = in_blue;
        drv_pix.alpha        = in_alpha;
        drv_pix.end_of_image = in_end_of_image;
        awaited_q.push_back(pack_pixel(drv_pix, shadow_fmt, shadow_swap));
        accepted_count++;
      end
      if (out_valid && out_ready) begin
        got_word.packed_bytes   = out_packed_bytes;
        got_word.byte_count     = out_byte_count;
        got_word.last_pixel_out = out_last_pixel_out;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h/%0d/%0b", got_word.packed_bytes,
                                    got_word.byte_count, got_word.last_pixel_out));
        end else begin
          want_word = awaited_q.pop_front();
          if (got_word.packed_bytes !== want_word.packed_bytes)
            report_mismatch($sformatf("result %0d packed_bytes %h, want %h", result_count,
                                      got_word.packed_bytes, want_word.packed_bytes));
          if (got_word.byte_count !== want_word.byte_count)
            report_mismatch($sformatf("result %0d byte_count %0d, want %0d", result_count,
                                      got_word.byte_count, want_word.byte_count));
          if (got_word.last_pixel_out !== want_word.last_pixel_out)
            report_mismatch($sformatf("result %0d last_pixel_out %0b, want %0b",
                                      result_count, got_word.last_pixel_out,
                                      want_word.last_pixel_out));
        end
        result_count++;
      end
    end
  end

  // Stimulus: directed pixels over every setting, then random phases.
  initial begin
    int unsigned random_sent;
    int unsigned n;
    int unsigned phase;
    int unsigned f;
    int unsigned s;
    logic [CHAN_W-1:0] a;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings (RGB565, no swap) before any write.
    add_pixel(8'hFF, 8'h80, 8'h01, 8'hC3, 1'b1);
    wait_drained();

    // Every format, both swap settings, unused format code included.
    for (f = 0; f < 4; f++) begin
      for (s = 0; s < 2; s++) begin
        apply_config(CFG_DAT_W'(f), CFG_DAT_W'(s));
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);  // full scale
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);  // zero alpha clears colour in RGB565 and RGB8
        add_pixel(8'h5A, 8'hA5, 8'h0F, 8'h80, 1'b1);  // mixed bits, half alpha
        wait_drained();
      end
    end

    // Random phases; swap data may carry its unused upper bit.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_PIXELS) begin
      apply_config(CFG_DAT_W'($urandom_range(0, 3)), CFG_DAT_W'($urandom_range(0, 3)));
      // Every fourth phase runs flat out on both sides.
      send_gaps_on = (phase % 4) != 2;
      recv_gaps_on = (phase % 4) != 2;
      if (phase == 3) begin
        // Stall the output for a long stretch while the sender keeps offering.
        send_gaps_on = 1'b0;
        hold_reqs++;
      end
      n = $urandom_range(40, 75);
      repeat (n) begin
        a = pick_chan(12);
        add_pixel(pick_chan(6), pick_chan(6), pick_chan(6), a, $urandom_range(0, 7) == 0);
      end
      random_sent += n;
      phase++;
      // Pause the sender until every packed word has come back.
      wait_drained();
    end

    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    wait_drained();
    if (awaited_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_q.size()));
    if (err_count == 0) begin
      $display("PASS rgba_premultiply_pixel_packer_core");
    end else begin
      $display("FAIL rgba_premultiply_pixel_packer_core");
    end
    $finish;
  end

  // Watchdog: end the run if the handshakes stop moving.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL rgba_premultiply_pixel_packer_core");
    $finish;
  end

endmodule
